// ===== hw/rtl/cfd_pkg.sv =====
package cfd_pkg;

  // Frame layout
  localparam int HASH_END     = 32;
  localparam int INDEX_END    = 36;
  localparam int OFFSET_END   = 44;
  localparam int HEADER_BYTES = 48;

  // Hard cap on the payload length limit
  localparam int MAX_CHUNK_LIMIT = 1048576;

  localparam int COUNT_W = 21;
  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

  // Configuration
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 41;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FILE  = 2'd1;
  localparam logic [20:0] MAX_CHUNK_RESET = 21'd65536;
  localparam logic [40:0] MAX_FILE_RESET  = 41'd4294967296;

  // Result kinds
  localparam logic [1:0] KIND_HASH    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SIZE   = 2'd1;
  localparam logic [1:0] ST_LENGTH = 2'd2;
  localparam logic [1:0] ST_OFFSET = 2'd3;

  localparam int QUEUE_DEPTH = 3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] chunk_index;
    logic [40:0] chunk_offset;
    logic [20:0] payload_length;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Results produced by one input item, in order
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

// ===== hw/rtl/cfd_decode.sv =====
module cfd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  cfd_pkg::in_item_t   in_item,
  input  logic [20:0]         max_chunk_bytes,
  input  logic [40:0]         max_file_bytes,
  output cfd_pkg::push_t      push
);

  logic [cfd_pkg::COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [31:0] index_word_r, index_word_nxt;
  logic [63:0] offset_word_r, offset_word_nxt;
  logic [31:0] length_word_r, length_word_nxt;

  logic [20:0] limit;
  logic [21:0] bound;
  logic [cfd_pkg::COUNT_W-1:0] p;
  logic [cfd_pkg::COUNT_W-1:0] size;
  logic is_hash, is_index, is_offset, is_length, is_payload;
  logic size_bad, len_bad, off_bad;
  logic [1:0] st;
  cfd_pkg::out_item_t byte_res, verdict_res;

  assign p = byte_count_r;

  always_comb begin
    if ({4'b0, max_chunk_bytes} > 25'(cfd_pkg::MAX_CHUNK_LIMIT)) begin
      limit = 21'(cfd_pkg::MAX_CHUNK_LIMIT);
    end else begin
      limit = max_chunk_bytes;
    end
  end

  assign bound = {1'b0, limit} + 22'(cfd_pkg::HEADER_BYTES);

  assign is_hash    = p < 21'(cfd_pkg::HASH_END);
  assign is_index   = !is_hash && (p < 21'(cfd_pkg::INDEX_END));
  assign is_offset  = (p >= 21'(cfd_pkg::INDEX_END)) && (p < 21'(cfd_pkg::OFFSET_END));
  assign is_length  = (p >= 21'(cfd_pkg::OFFSET_END)) && (p < 21'(cfd_pkg::HEADER_BYTES));
  assign is_payload = (p >= 21'(cfd_pkg::HEADER_BYTES)) && (p != cfd_pkg::COUNT_SAT)
                      && ({1'b0, p} < bound);

  always_comb begin
    index_word_nxt  = index_word_r;
    offset_word_nxt = offset_word_r;
    length_word_nxt = length_word_r;
    if (is_index) begin
      index_word_nxt = {index_word_r[23:0], in_item.frame_byte};
    end
    if (is_offset) begin
      offset_word_nxt = {offset_word_r[55:0], in_item.frame_byte};
    end
    if (is_length) begin
      length_word_nxt = {length_word_r[23:0], in_item.frame_byte};
    end
  end

  assign size = (p == cfd_pkg::COUNT_SAT) ? p : p + 21'd1;

  // Verdict checks on the words as updated by this byte
  assign size_bad = ({1'b0, size} <= 22'(cfd_pkg::HEADER_BYTES)) || ({1'b0, size} > bound);
  assign len_bad  = (length_word_nxt == 32'd0) || (length_word_nxt > {11'b0, limit})
                    || ({12'b0, size} != ({1'b0, length_word_nxt}
                                          + 33'(cfd_pkg::HEADER_BYTES)));
  assign off_bad  = (offset_word_nxt > {23'b0, max_file_bytes})
                    || ({9'b0, length_word_nxt} > (max_file_bytes - offset_word_nxt[40:0]));

  always_comb begin
    priority if (size_bad) begin
      st = cfd_pkg::ST_SIZE;
    end else if (len_bad) begin
      st = cfd_pkg::ST_LENGTH;
    end else if (off_bad) begin
      st = cfd_pkg::ST_OFFSET;
    end else begin
      st = cfd_pkg::ST_OK;
    end
  end

  always_comb begin
    byte_res                = '0;
    byte_res.kind           = is_hash ? cfd_pkg::KIND_HASH : cfd_pkg::KIND_PAYLOAD;
    byte_res.out_byte       = in_item.frame_byte;

    verdict_res             = '0;
    verdict_res.kind        = cfd_pkg::KIND_VERDICT;
    verdict_res.chunk_index = index_word_nxt;
    verdict_res.chunk_offset = (st == cfd_pkg::ST_OK) ? offset_word_nxt[40:0] : 41'd0;
    verdict_res.payload_length = (length_word_nxt > {11'b0, cfd_pkg::COUNT_SAT})
                                 ? 21'h1FFFFF : length_word_nxt[20:0];
    verdict_res.status      = st;
    verdict_res.last        = 1'b1;

    push = '0;
    if (accept) begin
      if (is_hash || is_payload) begin
        push.cnt   = in_item.frame_end ? 2'd2 : 2'd1;
        push.first = byte_res;
        push.first.last = !in_item.frame_end;
        push.second = verdict_res;
      end else if (in_item.frame_end) begin
        push.cnt   = 2'd1;
        push.first = verdict_res;
      end
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (accept) begin
      byte_count_nxt = in_item.frame_end ? '0 : size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      index_word_r  <= '0;
      offset_word_r <= '0;
      length_word_r <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      if (in_item.frame_end) begin
        index_word_r  <= '0;
        offset_word_r <= '0;
        length_word_r <= '0;
      end else begin
        index_word_r  <= index_word_nxt;
        offset_word_r <= offset_word_nxt;
        length_word_r <= length_word_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.frame_end |=> byte_count_r == '0 && length_word_r == '0)
    else $error("frame state not cleared after frame end");

  a_ok_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.frame_end && st == cfd_pkg::ST_OK
      |-> verdict_res.payload_length != 21'd0 && size > 21'(cfd_pkg::HEADER_BYTES))
    else $error("ok verdict with empty payload");
`endif

endmodule

// ===== hw/rtl/cfd_out_queue.sv =====
module cfd_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cfd_pkg::push_t     push,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output cfd_pkg::out_item_t out_item
);

  // Head always sits in entry 0; entries shift down on a pop.
  cfd_pkg::out_item_t q_r   [cfd_pkg::QUEUE_DEPTH];
  cfd_pkg::out_item_t q_nxt [cfd_pkg::QUEUE_DEPTH];
  logic [1:0] count_r, count_nxt;
  logic [1:0] base;
  logic       pop;

  assign out_valid = count_r != 2'd0;
  assign out_item  = q_r[0];
  assign pop       = out_valid && !out_stall;
  // Room for two results is always kept before taking an item
  assign full      = count_r >= 2'd2;
  assign base      = count_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < cfd_pkg::QUEUE_DEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[cfd_pkg::QUEUE_DEPTH-1] = q_r[cfd_pkg::QUEUE_DEPTH-1];
    for (int i = 0; i < cfd_pkg::QUEUE_DEPTH; i++) begin
      if ((push.cnt != 2'd0) && (base == 2'(i))) begin
        q_nxt[i] = push.first;
      end
      if ((push.cnt == 2'd2) && ((base + 2'd1) == 2'(i))) begin
        q_nxt[i] = push.second;
      end
    end
    count_nxt = base + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cfd_pkg::QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} - {2'b0, pop} + {1'b0, push.cnt}) <= 3'(cfd_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> !full)
    else $error("results pushed while queue full");
`endif

endmodule

// ===== hw/rtl/chunk_frame_decoder.sv =====
// Chunk frame decoder: takes one frame byte per item (32-byte hash, big-endian
// 32-bit index, 64-bit offset, 32-bit length, payload) and returns hash and
// payload bytes tagged by kind, plus one verdict item on the byte flagged
// frame_end. Header bytes give no result. A byte is accepted each cycle that
// in_stall is low; its results are registered in the result queue. A hash or
// payload byte that also ends the frame yields two results, and the 3-entry
// result queue raises in_stall while it holds two or more items, so the rate
// is one item per cycle while out_stall is low, bar a stall after each frame.
// cfg_ready is always high; write the limits only while no frame is in progress.
module chunk_frame_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cfd_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cfd_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [20:0] max_chunk_bytes_r;
  logic [40:0] max_file_bytes_r;
  logic        accept;
  logic        full;
  cfd_pkg::push_t push;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  // Limit registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_bytes_r <= cfd_pkg::MAX_CHUNK_RESET;
      max_file_bytes_r  <= cfd_pkg::MAX_FILE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cfd_pkg::REG_MAX_CHUNK) begin
        max_chunk_bytes_r <= cfg_data[20:0];
      end
      if (cfg_index == cfd_pkg::REG_MAX_FILE) begin
        max_file_bytes_r <= cfg_data[40:0];
      end
    end
  end

  // Per-byte decode: counter, header capture, verdict checks
  cfd_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_item         (in_item),
    .max_chunk_bytes (max_chunk_bytes_r),
    .max_file_bytes  (max_file_bytes_r),
    .push            (push)
  );

  // Result register stage, decouples the output side
  cfd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
